// ===== rtl/shdpl_pkg.sv =====
// Package for the string hash double-probe lookup block.
// Mode codes, table dimensions and shared types. No dependencies.
package shdpl_pkg;

    localparam logic [1:0] MODE_LOAD_CHAR = 2'd0;
    localparam logic [1:0] MODE_SET_USED  = 2'd1;
    localparam logic [1:0] MODE_QUERY     = 2'd2;

    localparam int TABLE_DEPTH = 1024;
    localparam int WORD_CHARS  = 64;

    localparam int CHAR_W = 7;
    localparam int HASH_W = 32;

    typedef struct packed {
        logic [9:0] found_bucket;
        logic       matched;
        logic       table_full;
        logic       too_long;
    } result_t;

endpackage

// ===== rtl/shdpl_mod.sv =====
// Sequential remainder unit: a % d, one quotient bit per cycle.
// Depends on shdpl_pkg for widths.
module shdpl_mod #(
    parameter int DW = 21
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [shdpl_pkg::HASH_W-1:0] dividend,
    input  logic [DW-1:0]               divisor,
    output logic                        done,
    output logic [DW-1:0]               remainder
);
    localparam int CW = $clog2(shdpl_pkg::HASH_W + 1);

    logic [shdpl_pkg::HASH_W-1:0] q_reg, q_next;
    logic [DW:0]                  r_reg, r_next;
    logic [CW-1:0]                cnt_reg, cnt_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [DW:0]                  shifted;

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {r_reg[DW-1:0], q_reg[shdpl_pkg::HASH_W-1]};
        if (start) begin
            q_next    = dividend;
            r_next    = '0;
            cnt_next  = CW'(shdpl_pkg::HASH_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            q_next = {q_reg[shdpl_pkg::HASH_W-2:0], 1'b0};
            if (shifted >= {1'b0, divisor}) begin
                r_next = shifted - {1'b0, divisor};
            end else begin
                r_next = shifted;
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign done      = done_reg;
    assign remainder = r_reg[DW-1:0];
endmodule

// ===== rtl/string_hash_double_probe_lookup.sv =====
// String hash double-probe lookup: load items write stored words and used
// flags, query items stream characters; a result is issued per query end.
// Loads, unused-mode items and non-final query characters are taken in the idle
// state. A final query character starts two remainder passes (start bucket
// and step) in one shared serial divider, then probing, reading the word memory
// one character a cycle: each probe reads the used flag (ST_USED, ST_CHK) and
// stops on a free bucket; else ST_CMP compares characters up to the terminator
// and a match stops, while a mismatch or a long query steps on in ST_NEXT; a
// final ST_OUT state hands the result to the output register.
// Input is refused while a query's remainders are formed and while it is probed,
// and while its result waits for the output register to empty. The used-flag
// memory needs a clearing pass over all TABLE_DEPTH entries after reset, during which no item is taken.
module string_hash_double_probe_lookup (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata,      // table_size
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,        // bucket_index[9:0] char_pos[15:10] char_value[22:16] used_flag[23]
    input  logic [1:0]  s_tuser,        // mode
    input  logic        s_tlast,        // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata         // found_bucket[9:0] matched[10] table_full[11] too_long[12]
);
    localparam int TABLE_DEPTH = shdpl_pkg::TABLE_DEPTH;
    localparam int WORD_CHARS  = shdpl_pkg::WORD_CHARS;
    localparam int BW  = $clog2(TABLE_DEPTH);
    localparam int PW  = $clog2(WORD_CHARS);
    localparam int LW  = $clog2(WORD_CHARS + 1);
    localparam int SW  = BW + 1;
    localparam int AW  = BW + PW;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_MOD1  = 4'd2;
    localparam logic [3:0] ST_MOD2  = 4'd3;
    localparam logic [3:0] ST_USED  = 4'd4;
    localparam logic [3:0] ST_CHK   = 4'd5;
    localparam logic [3:0] ST_CMP   = 4'd6;
    localparam logic [3:0] ST_NEXT  = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;

    logic [1:0]  in_mode;
    logic [9:0]  in_bidx;
    logic [5:0]  in_pos;
    logic [6:0]  in_ch;
    logic        in_uflag;
    assign in_bidx  = s_tdata[9:0];
    assign in_pos   = s_tdata[15:10];
    assign in_ch    = s_tdata[22:16];
    assign in_uflag = s_tdata[23];
    assign in_mode  = s_tuser;

    logic [3:0]  st_reg, st_next;
    logic [10:0] tsize_reg;
    logic [31:0] hash_reg, hash_next;
    logic [LW-1:0] qlen_reg, qlen_next;
    logic [SW-1:0] size_reg, size_next, step_reg, step_next;
    logic [BW-1:0] h_reg, h_next;
    logic [SW-1:0] pcnt_reg, pcnt_next;
    logic [LW-1:0] j_reg, j_next;
    logic        toolong_reg, toolong_next;
    logic [BW-1:0] clr_reg, clr_next;
    logic        mv_reg, mv_next;
    shdpl_pkg::result_t res_reg, res_next;
    shdpl_pkg::result_t pend_reg, pend_next;

    logic        used_mem [TABLE_DEPTH];
    logic [6:0]  word_mem [TABLE_DEPTH*WORD_CHARS];
    logic [6:0]  q_mem    [WORD_CHARS];
    logic        used_rd;
    logic [6:0]  word_rd, q_rd;

    logic        used_we;  logic [BW-1:0] used_wa; logic used_wd; logic [BW-1:0] used_ra;
    logic        word_we;  logic [AW-1:0] word_wa, word_ra;
    logic        q_we;     logic [PW-1:0] q_wa, q_ra;

    logic        acc;
    logic        div_start, div_done;
    logic [31:0] div_a;
    logic [SW-1:0] div_d, div_r;
    logic [SW-1:0] tsz_sat;
    logic [SW:0] hsum;

    assign acc = s_tvalid && s_tready;
    assign s_tready = (st_reg == ST_IDLE);

    always_comb begin
        if (tsize_reg < 11'd2) tsz_sat = SW'(2);
        else if ({1'b0, tsize_reg} > 12'(TABLE_DEPTH)) tsz_sat = SW'(TABLE_DEPTH);
        else tsz_sat = SW'(tsize_reg);
    end

    shdpl_mod #(.DW(SW)) u_mod (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(div_a),
        .divisor(div_d), .done(div_done), .remainder(div_r)
    );

    always_ff @(posedge aclk) begin
        if (used_we) used_mem[used_wa] <= used_wd;
        used_rd <= used_mem[used_ra];
        if (word_we) word_mem[word_wa] <= in_ch;
        word_rd <= word_mem[word_ra];
        if (q_we) q_mem[q_wa] <= in_ch;
        q_rd <= q_mem[q_ra];
    end

    always_comb begin
        st_next = st_reg; hash_next = hash_reg; qlen_next = qlen_reg;
        size_next = size_reg; step_next = step_reg; h_next = h_reg;
        pcnt_next = pcnt_reg; j_next = j_reg; toolong_next = toolong_reg;
        clr_next = clr_reg; mv_next = mv_reg; res_next = res_reg; pend_next = pend_reg;
        used_we = 1'b0; used_wa = in_bidx[BW-1:0]; used_wd = in_uflag; used_ra = h_reg;
        word_we = 1'b0; word_wa = {in_bidx[BW-1:0], in_pos[PW-1:0]};
        word_ra = {h_reg, j_reg[PW-1:0]};
        q_we = 1'b0; q_wa = qlen_reg[PW-1:0]; q_ra = j_reg[PW-1:0];
        div_start = 1'b0; div_a = hash_reg; div_d = size_reg;
        hsum = '0;
        if (mv_reg && m_tready) mv_next = 1'b0;
        case (st_reg)
            ST_CLEAR: begin
                used_we = 1'b1; used_wa = clr_reg; used_wd = 1'b0;
                clr_next = clr_reg + BW'(1);
                if (clr_reg == BW'(TABLE_DEPTH - 1)) st_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (acc) begin
                    case (in_mode)
                        shdpl_pkg::MODE_LOAD_CHAR: begin
                            word_we = ({22'd0, in_bidx} < 32'(TABLE_DEPTH))
                                   && ({26'd0, in_pos} < 32'(WORD_CHARS));
                        end
                        shdpl_pkg::MODE_SET_USED: begin
                            used_we = {22'd0, in_bidx} < 32'(TABLE_DEPTH);
                        end
                        shdpl_pkg::MODE_QUERY: begin
                            if (in_ch != 7'd0) begin
                                hash_next = (hash_reg << 5) + hash_reg + 32'(in_ch);
                                q_we = qlen_reg < LW'(WORD_CHARS - 1);
                                if (qlen_reg < LW'(WORD_CHARS)) qlen_next = qlen_reg + LW'(1);
                            end
                            if (s_tlast) begin
                                size_next = tsz_sat;
                                st_next = ST_MOD1;
                                div_start = 1'b1;
                                div_a = hash_next;
                                div_d = tsz_sat;
                                hash_next = hash_next;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_MOD1: begin
                toolong_next = qlen_reg > LW'(WORD_CHARS - 1);
                if (div_done) begin
                    h_next = div_r[BW-1:0];
                    div_start = 1'b1;
                    div_d = size_reg - SW'(1);
                    st_next = ST_MOD2;
                end
            end
            ST_MOD2: begin
                div_d = size_reg - SW'(1);
                if (div_done) begin
                    step_next = div_r + SW'(1);
                    pcnt_next = '0;
                    st_next = ST_USED;
                end
            end
            ST_USED: begin
                j_next = '0;
                st_next = ST_CHK;
            end
            ST_CHK: begin
                if (!used_rd) begin
                    pend_next = '{found_bucket: 10'(h_reg), matched: 1'b0,
                                  table_full: 1'b0, too_long: toolong_reg};
                    st_next = ST_OUT;
                end else if (toolong_reg) begin
                    st_next = ST_NEXT;
                end else begin
                    st_next = ST_CMP;
                end
            end
            ST_CMP: begin
                if (j_reg == qlen_reg) begin
                    if (j_reg == LW'(WORD_CHARS) || word_rd == 7'd0) begin
                        pend_next = '{found_bucket: 10'(h_reg), matched: 1'b1,
                                      table_full: 1'b0, too_long: toolong_reg};
                        st_next = ST_OUT;
                    end else st_next = ST_NEXT;
                end else if (word_rd != q_rd) begin
                    st_next = ST_NEXT;
                end else begin
                    j_next = j_reg + LW'(1);
                    word_ra = {h_reg, j_next[PW-1:0]};
                    q_ra = j_next[PW-1:0];
                end
            end
            ST_NEXT: begin
                hsum = {2'b0, h_reg} + {1'b0, step_reg};
                if (hsum >= {1'b0, size_reg}) hsum = hsum - {1'b0, size_reg};
                h_next = hsum[BW-1:0];
                pcnt_next = pcnt_reg + SW'(1);
                if (pcnt_reg + SW'(1) == size_reg) begin
                    pend_next = '{found_bucket: 10'd0, matched: 1'b0,
                                  table_full: 1'b1, too_long: toolong_reg};
                    st_next = ST_OUT;
                end else begin
                    used_ra = h_next;
                    st_next = ST_USED;
                end
            end
            ST_OUT: begin
                if (!mv_reg || m_tready) begin
                    mv_next = 1'b1;
                    res_next = pend_reg;
                    hash_next = '0;
                    qlen_next = '0;
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_CLEAR; clr_reg <= '0; mv_reg <= 1'b0;
            tsize_reg <= 11'd1024; hash_reg <= '0; qlen_reg <= '0;
        end else begin
            st_reg <= st_next; clr_reg <= clr_next; mv_reg <= mv_next;
            if (cfg_we) tsize_reg <= cfg_wdata;
            hash_reg <= hash_next; qlen_reg <= qlen_next;
        end
        size_reg <= size_next; step_reg <= step_next; h_reg <= h_next;
        pcnt_reg <= pcnt_next; j_reg <= j_next; toolong_reg <= toolong_next;
        res_reg <= res_next; pend_reg <= pend_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {3'd0, res_reg.too_long, res_reg.table_full, res_reg.matched,
                       res_reg.found_bucket};
endmodule

// ===== rtl/shdpl_checker.sv =====
// Port-level checker for string_hash_double_probe_lookup, bound to the top.
// Depends only on the top-level ports.
module shdpl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[11] |-> m_tdata[9:0] == 10'd0 && !m_tdata[10])
        else $error("full with bucket");
    a_long: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[12] |-> !m_tdata[10]) else $error("long query matched");
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:13] == 3'd0) else $error("padding bits set");
endmodule

bind string_hash_double_probe_lookup shdpl_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for string_hash_double_probe_lookup: a directed table, then
// phased random loads and queries over several table sizes, checked by an in-bench lookup model.
// Depends on rtl/shdpl_pkg.sv and rtl/string_hash_double_probe_lookup.sv.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 1024;
    localparam int WCH   = 64;
    localparam int STALL_LIMIT = 400000;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0] mode;
        logic [9:0] bkt;
        logic [5:0] pos;
        logic [6:0] ch;
        logic       uflag;
        logic       last;
    } xfer_t;

    typedef struct packed {
        xfer_t              x;
        logic               typed;
        shdpl_pkg::result_t res;
    } row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [10:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    string_hash_double_probe_lookup dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .s_tlast(s_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // lookup model state
    logic [6:0]  words   [DEPTH][WCH];
    bit          written [DEPTH][WCH];
    bit          used    [DEPTH];
    logic [6:0]  qchars  [WCH];
    logic [31:0] hash_acc;
    int          qlen;
    logic [10:0] size_reg;

    shdpl_pkg::result_t lookups_due[$];
    int      loaded[$];
    int      errors;
    bit      no_idle;
    bit      hold_req;
    int      quiet_cycles;

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    function automatic bit word_same(int b);
        for (int j = 0; j < qlen; j++)
            if (words[b][j] != qchars[j]) return 0;
        if (qlen < WCH && words[b][qlen] != 0) return 0;
        return 1;
    endfunction

    function automatic bit word_ready(int b);
        for (int p = 0; p < WCH; p++) begin
            if (!written[b][p]) return 0;
            if (words[b][p] == 0) return 1;
        end
        return 1;
    endfunction

    function automatic bit lookup_step(xfer_t x, output shdpl_pkg::result_t r);
        int sz, h, stp;
        bit long_q, done, hit;
        r = '0;
        case (x.mode)
            shdpl_pkg::MODE_LOAD_CHAR: begin
                words[x.bkt][x.pos] = x.ch;
                written[x.bkt][x.pos] = 1;
                return 0;
            end
            shdpl_pkg::MODE_SET_USED: begin
                used[x.bkt] = x.uflag;
                return 0;
            end
            shdpl_pkg::MODE_QUERY: ;
            default: return 0;
        endcase
        if (x.ch != 0) begin
            hash_acc = hash_acc * 32'd33 + 32'(x.ch);
            if (qlen < WCH - 1) qchars[qlen] = x.ch;
            if (qlen < WCH) qlen++;
        end
        if (!x.last) return 0;
        sz = int'(size_reg);
        if (sz < 2) sz = 2;
        if (sz > DEPTH) sz = DEPTH;
        long_q = qlen > WCH - 1;
        h = hash_acc % sz;
        stp = 1 + hash_acc % (sz - 1);
        done = 0;
        hit = 0;
        for (int i = 0; i < sz; i++) begin
            if (!used[h]) begin
                done = 1;
                break;
            end
            if (!long_q && word_same(h)) begin
                done = 1;
                hit = 1;
                break;
            end
            h += stp;
            if (h >= sz) h -= sz;
        end
        r.found_bucket = done ? h[9:0] : '0;
        r.matched = hit;
        r.table_full = !done;
        r.too_long = long_q;
        hash_acc = 0;
        qlen = 0;
        return 1;
    endfunction

    task automatic send_item(xfer_t x, bit typed = 0, shdpl_pkg::result_t typed_res = '0);
        shdpl_pkg::result_t r;
        @(negedge aclk);
        while (!no_idle && $urandom_range(99) < 7) begin
            s_tvalid = 0;
            @(negedge aclk);
        end
        s_tvalid = 1;
        s_tdata  = {x.uflag, x.ch, x.pos, x.bkt};
        s_tuser  = x.mode;
        s_tlast  = x.last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (lookup_step(x, r)) lookups_due.push_back(typed ? typed_res : r);
    endtask

    task automatic send_op(logic [1:0] m, int b, int p, int c, int u, int l);
        xfer_t x;
        x.mode = m; x.bkt = 10'(b); x.pos = 6'(p); x.ch = 7'(c);
        x.uflag = u[0]; x.last = l[0];
        send_item(x);
    endtask

    task automatic drain(int extra);
        @(negedge aclk);
        s_tvalid = 0;
        while (lookups_due.size() != 0) @(negedge aclk);
        repeat (extra) @(negedge aclk);
    endtask

    task automatic write_size(logic [10:0] v);
        drain(40);
        cfg_we = 1;
        cfg_wdata = v;
        size_reg = v;
        @(negedge aclk);
        cfg_we = 0;
    endtask

    task automatic load_word(int b, int len, bit term);
        for (int p = 0; p < len; p++)
            send_op(shdpl_pkg::MODE_LOAD_CHAR, b, p,
                    $urandom_range(3) == 0 ? $urandom_range(1, 127) : $urandom_range(97, 100),
                    0, 0);
        if (term) send_op(shdpl_pkg::MODE_LOAD_CHAR, b, len, 0, $urandom_range(1), 0);
        send_op(shdpl_pkg::MODE_SET_USED, b, $urandom_range(63), $urandom_range(127), 1, 0);
        loaded.push_back(b);
    endtask

    task automatic send_query(logic [6:0] s[$]);
        if (s.size() == 0) begin
            send_op(shdpl_pkg::MODE_QUERY, $urandom_range(1023), $urandom_range(63), 0,
                    $urandom_range(1), 1);
            return;
        end
        for (int i = 0; i < s.size(); i++) begin
            if ($urandom_range(19) == 0)
                send_op(shdpl_pkg::MODE_QUERY, $urandom_range(1023), $urandom_range(63), 0,
                        $urandom_range(1), 0);
            send_op(shdpl_pkg::MODE_QUERY, $urandom_range(1023), $urandom_range(63),
                    int'(s[i]), $urandom_range(1), int'(i == s.size() - 1));
        end
    endtask

    // receiver
    initial begin
        int hold;
        m_tready = 0;
        hold = 0;
        forever begin
            @(negedge aclk);
            if (hold_req && hold == 0) hold = 400;
            if (hold > 0) begin
                hold--;
                m_tready = 0;
            end else begin
                m_tready = no_idle || $urandom_range(99) >= 7;
            end
        end
    end

    // result check and watchdog
    always @(posedge aclk) begin
        shdpl_pkg::result_t want, got;
        if (aresetn && ((s_tvalid && s_tready) || (m_tvalid && m_tready)))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("%0t watchdog: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            got.found_bucket = m_tdata[9:0];
            got.matched      = m_tdata[10];
            got.table_full   = m_tdata[11];
            got.too_long     = m_tdata[12];
            if (lookups_due.size() == 0) begin
                $display("%0t unexpected result: actual %p", $time, got);
                errors++;
            end else begin
                want = lookups_due.pop_front();
                if (got.found_bucket != want.found_bucket || got.matched != want.matched ||
                    got.table_full != want.table_full || got.too_long != want.too_long ||
                    m_tdata[15:13] != 0) begin
                    $display("%0t result mismatch: expected %p actual %p (tdata %h)",
                             $time, want, got, m_tdata);
                    errors++;
                end
            end
        end
    end

    row_t dir_rows [14];

    initial begin
        logic [10:0] sizes [10];
        logic [6:0] q[$];
        int sz, n, b, len, sel;

        sizes = '{11'd2, 11'd0, 11'd1, 11'd7, 11'd16,
                  11'd61, 11'd1024, 11'd2047, 11'd300, 11'd5};
        errors = 0;
        quiet_cycles = 0;
        no_idle = 0;
        hold_req = 0;
        hash_acc = 0;
        qlen = 0;
        size_reg = 11'd1024;
        foreach (used[i]) used[i] = 0;
        foreach (written[i, j]) written[i][j] = 0;
        foreach (qchars[i]) qchars[i] = 0;
        aresetn = 0;
        cfg_we = 0;
        cfg_wdata = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tuser = 0;
        s_tlast = 0;

        dir_rows = '{
            '{'{shdpl_pkg::MODE_QUERY, 10'd0, 6'd0, 7'd97, 1'b0, 1'b1}, 1'b1,
              '{10'd97, 1'b0, 1'b0, 1'b0}},
            '{'{shdpl_pkg::MODE_QUERY, 10'd5, 6'd5, 7'd0, 1'b1, 1'b1}, 1'b1,
              '{10'd0, 1'b0, 1'b0, 1'b0}},
            '{'{MODE_SPARE, 10'd1023, 6'd63, 7'd127, 1'b1, 1'b1}, 1'b0, '0},
            '{'{shdpl_pkg::MODE_LOAD_CHAR, 10'd97, 6'd0, 7'd97, 1'b0, 1'b0}, 1'b0, '0},
            '{'{shdpl_pkg::MODE_LOAD_CHAR, 10'd97, 6'd1, 7'd0, 1'b0, 1'b0}, 1'b0, '0},
            '{'{shdpl_pkg::MODE_SET_USED, 10'd97, 6'd0, 7'd0, 1'b1, 1'b0}, 1'b0, '0},
            '{'{shdpl_pkg::MODE_QUERY, 10'd0, 6'd0, 7'd97, 1'b0, 1'b1}, 1'b1,
              '{10'd97, 1'b1, 1'b0, 1'b0}},
            '{'{shdpl_pkg::MODE_QUERY, 10'd0, 6'd0, 7'd98, 1'b0, 1'b1}, 1'b1,
              '{10'd98, 1'b0, 1'b0, 1'b0}},
            '{'{shdpl_pkg::MODE_LOAD_CHAR, 10'd1023, 6'd63, 7'd127, 1'b1, 1'b1}, 1'b0, '0},
            '{'{shdpl_pkg::MODE_SET_USED, 10'd1023, 6'd63, 7'd127, 1'b0, 1'b1}, 1'b0, '0},
            '{'{shdpl_pkg::MODE_QUERY, 10'd0, 6'd0, 7'd127, 1'b0, 1'b0}, 1'b0, '0},
            '{'{shdpl_pkg::MODE_QUERY, 10'd0, 6'd0, 7'd0, 1'b0, 1'b0}, 1'b0, '0},
            '{'{shdpl_pkg::MODE_QUERY, 10'd0, 6'd0, 7'd97, 1'b0, 1'b1}, 1'b1,
              '{10'd192, 1'b0, 1'b0, 1'b0}},
            '{'{shdpl_pkg::MODE_QUERY, 10'd0, 6'd0, 7'd97, 1'b0, 1'b0}, 1'b0, '0}
        };

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        foreach (dir_rows[i]) send_item(dir_rows[i].x, dir_rows[i].typed, dir_rows[i].res);
        q = {7'd97, 7'd97};
        send_query(q);
        loaded.push_back(97);

        for (int ph = 0; ph < 10; ph++) begin
            write_size(sizes[ph]);
            sz = sizes[ph] < 2 ? 2 : (sizes[ph] > DEPTH ? DEPTH : sizes[ph]);
            if (ph == 6) no_idle = 1;
            if (ph == 7) no_idle = 0;
            if (ph == 2 || ph == 9)
                while (loaded.size() != 0) begin
                    b = loaded.pop_front();
                    send_op(shdpl_pkg::MODE_SET_USED, b, $urandom_range(63),
                            $urandom_range(127), 0, 0);
                end
            n = 0;
            for (int k = 0; k < 25; k++) begin
                if (ph == 3 && k == 10) hold_req = 1;
                if (ph == 3 && k == 11) hold_req = 0;
                if (ph == 5 && k == 12) drain(0);
                sel = $urandom_range(99);
                if (sel < 25 && n < (sz < 40 ? sz : 40)) begin
                    b = $urandom_range(sz - 1);
                    if ($urandom_range(19) == 0) load_word(b, WCH, 0);
                    else load_word(b, $urandom_range(1, 5), 1);
                    n++;
                end else if (sel < 80) begin
                    q.delete();
                    if (loaded.size() != 0 && $urandom_range(1)) begin
                        b = loaded[$urandom_range(loaded.size() - 1)];
                        if (word_ready(b))
                            for (int p = 0; p < WCH && words[b][p] != 0; p++)
                                q.push_back(words[b][p]);
                    end else begin
                        len = $urandom_range(1, 4);
                        for (int p = 0; p < len; p++)
                            q.push_back($urandom_range(3) == 0 ? 7'($urandom_range(1, 127))
                                                               : 7'($urandom_range(97, 100)));
                    end
                    send_query(q);
                end else if (sel < 88) begin
                    send_op(MODE_SPARE, $urandom_range(1023), $urandom_range(63),
                            $urandom_range(127), $urandom_range(1), $urandom_range(1));
                end else if (sel < 93) begin
                    b = $urandom_range(1023);
                    if (!used[b])
                        send_op(shdpl_pkg::MODE_LOAD_CHAR, b, $urandom_range(63),
                                $urandom_range(127), $urandom_range(1), $urandom_range(1));
                    else
                        send_op(MODE_SPARE, b, $urandom_range(63), $urandom_range(127),
                                $urandom_range(1), $urandom_range(1));
                end else if (sel < 96) begin
                    b = $urandom_range(sz - 1);
                    send_op(shdpl_pkg::MODE_SET_USED, b, $urandom_range(63), $urandom_range(127),
                            word_ready(b) ? $urandom_range(1) : 0, $urandom_range(1));
                end else if (sel < 98) begin
                    q.delete();
                    len = $urandom_range(63, 70);
                    for (int p = 0; p < len; p++) q.push_back(7'($urandom_range(1, 127)));
                    send_query(q);
                end else begin
                    q.delete();
                    send_query(q);
                end
            end
        end

        drain(60);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/shdpl_pkg.sv
rtl/shdpl_mod.sv
rtl/string_hash_double_probe_lookup.sv
rtl/shdpl_checker.sv
tb/sv/testbench.sv
